// ===== rtl/core/dbm_pkg.sv =====
package dbm_pkg;

	// Configuration register indexes.
	localparam logic [1:0] RegDebounceTicks = 2'd0;
	localparam logic [1:0] RegMidiChannel   = 2'd1;
	localparam logic [1:0] RegBaseNote      = 2'd2;
	localparam logic [1:0] RegNoteVelocity  = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [7:0] DebounceTicksRst = 8'd20;
	localparam logic [3:0] MidiChannelRst   = 4'd0;
	localparam logic [6:0] BaseNoteRst      = 7'h60;
	localparam logic [6:0] NoteVelocityRst  = 7'h7F;

	// USB-MIDI code index values, also the high nibble of the status byte.
	localparam logic [3:0] CodeNoteOn  = 4'h9;
	localparam logic [3:0] CodeNoteOff = 4'h8;

	// At most this many events leave for one confirmed tick.
	localparam int MaxEvents = 2;
	localparam int EvCntW    = (MaxEvents > 1) ? $clog2(MaxEvents) : 1;

	// Depth of the job queue between debounce front and event back end.
	localparam int JobQueueDepth = 2;
	localparam int JobPtrW       = $clog2(JobQueueDepth);

	typedef struct packed {
		logic [7:0] debounce_ticks;
		logic [3:0] chan_nibble;
		logic [6:0] base_note;
		logic [6:0] note_velocity;
	} cfg_t;

endpackage

// ===== rtl/core/dbm_if.sv =====
// Button tick channel: one sample per timer tick.
interface dbm_tick_if #(
	parameter int NUM_BUTTONS = 2
);
	logic                   valid;
	logic                   ready;
	logic [NUM_BUTTONS-1:0] button_sample;

	modport source (output valid, output button_sample, input ready);
	modport sink (input valid, input button_sample, output ready);
endinterface

// Note event channel: one USB-MIDI event per word.
interface dbm_note_if;
	logic       valid;
	logic       ready;
	logic [3:0] code_index;
	logic [7:0] status_byte;
	logic [6:0] note_number;
	logic [6:0] velocity;
	logic       last_event;

	modport source (output valid, output code_index, output status_byte, output note_number,
		output velocity, output last_event, input ready);
	modport sink (input valid, input code_index, input status_byte, input note_number,
		input velocity, input last_event, output ready);
endinterface

// Configuration write channel.
interface dbm_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/dbm_cfg_regs.sv =====
module dbm_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	dbm_cfg_if.sink       cfg,
	output dbm_pkg::cfg_t cfg_regs
);

	dbm_pkg::cfg_t regs_q;

	// Writes are always accepted: ready is tied high.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.debounce_ticks <= dbm_pkg::DebounceTicksRst;
			regs_q.chan_nibble    <= dbm_pkg::MidiChannelRst;
			regs_q.base_note      <= dbm_pkg::BaseNoteRst;
			regs_q.note_velocity  <= dbm_pkg::NoteVelocityRst;
		end else if (cfg.valid) begin
			case (cfg.index)
				dbm_pkg::RegDebounceTicks: regs_q.debounce_ticks <= cfg.wdata;
				dbm_pkg::RegMidiChannel:   regs_q.chan_nibble    <= cfg.wdata[3:0];
				dbm_pkg::RegBaseNote:      regs_q.base_note      <= cfg.wdata[6:0];
				dbm_pkg::RegNoteVelocity:  regs_q.note_velocity  <= cfg.wdata[6:0];
				default: ;
			endcase
		end
	end

	assign cfg_regs = regs_q;

endmodule

// ===== rtl/core/dbm_front.sv =====
module dbm_front #(
	parameter int NUM_BUTTONS = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	dbm_tick_if.sink                   ticks,
	input  logic [7:0]                 debounce_ticks,
	output logic                       job_valid,
	input  logic                       job_ready,
	output logic [2*NUM_BUTTONS-1:0]   job_data
);

	logic [NUM_BUTTONS-1:0] stable_q;
	logic [NUM_BUTTONS-1:0] cand_q;
	logic                   running_q;
	logic [7:0]             count_q;

	logic [NUM_BUTTONS-1:0] sample;
	logic                   accept;
	logic [7:0]             target;
	logic [8:0]             count_inc;
	logic                   reached;

	// The queue always has room when a tick is taken, so a confirmed job is never dropped.
	assign ticks.ready = job_ready;
	assign accept      = ticks.valid && ticks.ready;
	assign sample      = ticks.button_sample;

	// A zero tick count behaves like one.
	assign target    = (debounce_ticks == 8'd0) ? 8'd1 : debounce_ticks;
	assign count_inc = {1'b0, count_q} + 9'd1;
	assign reached   = count_inc >= {1'b0, target};

	// Debounce state: latch a candidate, count ticks, then confirm or drop it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q  <= '0;
			cand_q    <= '0;
			running_q <= 1'b0;
			count_q   <= '0;
		end else if (accept) begin
			if (!running_q) begin
				if (sample != stable_q) begin
					cand_q    <= sample;
					running_q <= 1'b1;
					count_q   <= '0;
				end
			end else if (!reached) begin
				count_q <= count_inc[7:0];
			end else begin
				count_q   <= target;
				running_q <= 1'b0;
				if (sample == cand_q) begin
					stable_q <= sample;
				end
			end
		end
	end

	// A confirming resample hands the new sample and the changed buttons to the back end.
	assign job_valid = accept && running_q && reached && (sample == cand_q);
	assign job_data  = {sample, sample ^ stable_q};

endmodule

// ===== rtl/core/dbm_job_queue.sv =====
module dbm_job_queue #(
	parameter int WIDTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int CntW = $clog2(dbm_pkg::JobQueueDepth + 1);

	logic [WIDTH-1:0]           entry_q [dbm_pkg::JobQueueDepth];
	logic [dbm_pkg::JobPtrW-1:0] wr_ptr_q;
	logic [dbm_pkg::JobPtrW-1:0] rd_ptr_q;
	logic [CntW-1:0]            fill_q;

	logic push;
	logic pop;

	assign push_ready = fill_q != CntW'(dbm_pkg::JobQueueDepth);
	assign pop_valid  = fill_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/dbm_back.sv =====
module dbm_back #(
	parameter int NUM_BUTTONS = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     job_valid,
	output logic                     job_ready,
	input  logic [2*NUM_BUTTONS-1:0] job_data,
	input  dbm_pkg::cfg_t            cfg_regs,
	dbm_note_if.source               notes
);

	localparam int IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	logic [NUM_BUTTONS-1:0]     rem_q;
	logic [NUM_BUTTONS-1:0]     samp_q;
	logic                       busy_q;
	logic [dbm_pkg::EvCntW-1:0] n_q;

	logic       ovalid_q;
	logic [3:0] code_q;
	logic [7:0] status_q;
	logic [6:0] note_q;
	logic [6:0] vel_q;
	logic       last_q;

	logic [IdxW-1:0]        sel_idx;
	logic [NUM_BUTTONS-1:0] sel_bit;
	logic [NUM_BUTTONS-1:0] rem_next;
	logic                   last;
	logic                   emit_en;
	logic [3:0]             code;

	// Lowest changed button still waiting for its event.
	always_comb begin
		sel_idx = '0;
		for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
			if (rem_q[b]) begin
				sel_idx = IdxW'(b);
			end
		end
	end

	assign sel_bit  = NUM_BUTTONS'(1) << sel_idx;
	assign rem_next = rem_q & ~sel_bit;
	assign last     = (rem_next == '0) || (n_q == dbm_pkg::EvCntW'(dbm_pkg::MaxEvents - 1));
	assign emit_en  = busy_q && (!ovalid_q || notes.ready);
	assign code     = samp_q[sel_idx] ? dbm_pkg::CodeNoteOn : dbm_pkg::CodeNoteOff;

	// A new job loads while the last event of the previous one goes out.
	assign job_ready = !busy_q || (emit_en && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			samp_q <= '0;
			busy_q <= 1'b0;
			n_q    <= '0;
		end else if (job_valid && job_ready) begin
			samp_q <= job_data[2*NUM_BUTTONS-1:NUM_BUTTONS];
			rem_q  <= job_data[NUM_BUTTONS-1:0];
			busy_q <= 1'b1;
			n_q    <= '0;
		end else if (emit_en) begin
			rem_q <= rem_next;
			n_q   <= n_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit_en) begin
			ovalid_q <= 1'b1;
		end else if (notes.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			code_q   <= code;
			status_q <= {code, cfg_regs.chan_nibble};
			note_q   <= cfg_regs.base_note + 7'(sel_idx);
			vel_q    <= cfg_regs.note_velocity;
			last_q   <= last;
		end
	end

	assign notes.valid       = ovalid_q;
	assign notes.code_index  = code_q;
	assign notes.status_byte = status_q;
	assign notes.note_number = note_q;
	assign notes.velocity    = vel_q;
	assign notes.last_event  = last_q;

endmodule

// ===== rtl/core/debounced_buttons_to_midi_notes.sv =====
// Channel  Dir  Word
// cfg      in   index (register number), wdata (8-bit value)
// ticks    in   button_sample, one bit per button, 1 = pressed
// notes    out  code_index, status_byte, note_number, velocity, last_event
//
// A tick is taken every cycle while the two-entry job queue has room; a
// confirming tick lands a job there in the cycle it is taken.
// The back end sends one event word per cycle, so a tick that changes k
// buttons yields min(k, 2) words on consecutive cycles when notes.ready is high.
// Reset (arst_n low) clears the debounce state, the queue and the output register
// and loads the register defaults. A stall on notes fills the queue, then ticks wait.
module debounced_buttons_to_midi_notes #(
	parameter int NUM_BUTTONS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	dbm_cfg_if.sink     cfg,
	dbm_tick_if.sink    ticks,
	dbm_note_if.source  notes
);

	dbm_pkg::cfg_t cfg_regs;

	logic                     fr_valid;
	logic                     fr_ready;
	logic [2*NUM_BUTTONS-1:0] fr_data;
	logic                     bk_valid;
	logic                     bk_ready;
	logic [2*NUM_BUTTONS-1:0] bk_data;

	dbm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	dbm_front #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.ticks          (ticks),
		.debounce_ticks (cfg_regs.debounce_ticks),
		.job_valid      (fr_valid),
		.job_ready      (fr_ready),
		.job_data       (fr_data)
	);

	dbm_job_queue #(
		.WIDTH (2 * NUM_BUTTONS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_data),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_data)
	);

	dbm_back #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bk_valid),
		.job_ready (bk_ready),
		.job_data  (bk_data),
		.cfg_regs  (cfg_regs),
		.notes     (notes)
	);

endmodule

// ===== rtl/core/dbm_checker.sv =====
module dbm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] code_index,
	input logic [7:0] status_byte,
	input logic [6:0] note_number,
	input logic       last_event
);

	// A waiting event word holds until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(note_number) && $stable(status_byte))
		else $error("note word changed while stalled");

	// Every event is a note on or a note off, and the status nibble agrees.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (code_index == dbm_pkg::CodeNoteOn || code_index == dbm_pkg::CodeNoteOff)
			&& status_byte[7:4] == code_index)
		else $error("bad event code or status byte");

	// A taken word that is not the last of its tick is followed at once by the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_event |=> out_valid)
		else $error("event group broken off");

endmodule

bind debounced_buttons_to_midi_notes dbm_checker u_dbm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (notes.valid),
	.out_ready   (notes.ready),
	.code_index  (notes.code_index),
	.status_byte (notes.status_byte),
	.note_number (notes.note_number),
	.last_event  (notes.last_event)
);
